// ----- rtl/i2r_pkg.sv -----
package i2r_pkg;

  localparam int ValueWidth  = 12;
  localparam int SymbolWidth = 8;
  localparam int ConstWidth  = 10;
  localparam int StepWidth   = 5;
  localparam int MaxChars    = 15;
  localparam int CountWidth  = $clog2(MaxChars + 1);

  typedef logic [StepWidth-1:0]   step_t;
  typedef logic [SymbolWidth-1:0] symbol_t;
  typedef logic [ConstWidth-1:0]  kval_t;
  typedef logic [ValueWidth-1:0]  value_t;
  typedef logic [CountWidth-1:0]  count_t;

  // ascii codes
  localparam symbol_t SymI = 8'h49;
  localparam symbol_t SymV = 8'h56;
  localparam symbol_t SymX = 8'h58;
  localparam symbol_t SymL = 8'h4c;
  localparam symbol_t SymC = 8'h43;
  localparam symbol_t SymD = 8'h44;
  localparam symbol_t SymM = 8'h4d;

  // microprogram addresses
  localparam step_t StThou   = 5'd0;
  localparam step_t StH9     = 5'd1;
  localparam step_t StH9b    = 5'd2;
  localparam step_t StH5     = 5'd3;
  localparam step_t StH4     = 5'd4;
  localparam step_t StH4b    = 5'd5;
  localparam step_t StH1     = 5'd6;
  localparam step_t StT9     = 5'd7;
  localparam step_t StT9b    = 5'd8;
  localparam step_t StT5     = 5'd9;
  localparam step_t StT4     = 5'd10;
  localparam step_t StT4b    = 5'd11;
  localparam step_t StT1     = 5'd12;
  localparam step_t StU9     = 5'd13;
  localparam step_t StU9b    = 5'd14;
  localparam step_t StU5     = 5'd15;
  localparam step_t StU4     = 5'd16;
  localparam step_t StU4b    = 5'd17;
  localparam step_t StU1     = 5'd18;

  // one control word: a test step emits only if rem >= k, an emit step always does
  typedef struct packed {
    logic    cond_en;
    logic    sub;
    kval_t   k;
    symbol_t sym;
    step_t   jt;
    step_t   jf;
  } ucode_t;

  typedef struct packed {
    logic    load;
    value_t  value;
    logic    fire;
    logic    sub;
    kval_t   k;
    symbol_t sym;
    logic    last;
  } dp_ctrl_t;

  typedef struct packed {
    logic ge;
    logic rem_left_zero;
    logic out_valid;
  } dp_status_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

endpackage

// ----- rtl/int_to_roman_numeral_core.sv -----
// Integer to Roman numeral converter.
// Input channel: in_valid / in_ready with a 12-bit unsigned value. One value
// is taken whenever the sequencer is idle.
// Output channel: out_valid / out_ready carrying one ASCII character (symbol)
// per item, most significant first; last marks the final character. A value
// of zero yields no items. Thousands at 4000 and up give four M characters,
// and a numeral is cut off after fifteen characters.
// A small microprogram walks the subtractive table 1000, 900, 500, 400, ...
// one control word per cycle unless the output stalls: a test step compares
// the remainder against its constant and emits a character if it fits, an
// emit step always does. Each step either emits one character or makes one
// failed test, and the sequence ends on the character that brings the
// remainder to zero or on the fifteenth character. in_ready stays low until
// the final character is emitted, so no new value is taken while one runs.
// Values from 1000 emit on the first step, small values such as 1 first make
// their failed tests.
// When out_ready is low the pending character holds in the output register
// and the sequencer waits on its next emit step until that slot frees.
// Reset returns the sequencer to idle and drops out_valid.
module int_to_roman_numeral_core
  import i2r_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  value_t  value,
  output logic    out_valid,
  input  logic    out_ready,
  output symbol_t symbol,
  output logic    last
);

  state_t     state;
  state_t     state_next;
  step_t      step;
  step_t      step_next;
  count_t     count;
  count_t     count_next;
  ucode_t     cw;
  dp_ctrl_t   ctrl;
  dp_status_t status;

  logic taken;
  logic running;
  logic emit;
  logic fire;
  logic advance;
  logic is_last;

  i2r_ucode_rom u_rom (
    .step (step),
    .cw   (cw)
  );

  i2r_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .out_ready (out_ready),
    .status    (status),
    .symbol    (symbol),
    .last      (last)
  );

  assign out_valid = status.out_valid;
  assign in_ready  = (state == ST_IDLE);

  assign running = (state == ST_RUN);
  assign taken   = !cw.cond_en || status.ge;
  assign emit    = running && taken;
  assign fire    = emit && (!status.out_valid || out_ready);
  assign advance = running && (!emit || fire);
  assign is_last = status.rem_left_zero || (count == count_t'(MaxChars - 1));

  always_comb begin
    ctrl.load  = in_valid && in_ready;
    ctrl.value = value;
    ctrl.fire  = fire;
    ctrl.sub   = cw.sub;
    ctrl.k     = cw.k;
    ctrl.sym   = cw.sym;
    ctrl.last  = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= StThou;
      count <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    count_next = count;
    case (state)
      ST_IDLE: begin
        if (in_valid && (value != '0)) begin
          state_next = ST_RUN;
          step_next  = StThou;
          count_next = '0;
        end
      end
      ST_RUN: begin
        if (advance) begin
          step_next = taken ? cw.jt : cw.jf;
        end
        if (fire) begin
          count_next = count + count_t'(1);
          if (is_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/i2r_ucode_rom.sv -----
module i2r_ucode_rom
  import i2r_pkg::*;
(
  input  step_t  step,
  output ucode_t cw
);

  function automatic ucode_t word(logic cond_en, logic sub, int k, symbol_t sym,
                                  step_t jt, step_t jf);
    ucode_t w;
    w.cond_en = cond_en;
    w.sub     = sub;
    w.k       = kval_t'(k);
    w.sym     = sym;
    w.jt      = jt;
    w.jf      = jf;
    return w;
  endfunction

  always_comb begin
    case (step)
      StThou: cw = word(1'b1, 1'b1, 1000, SymM, StThou, StH9);
      StH9:   cw = word(1'b1, 1'b0, 900,  SymC, StH9b,  StH5);
      StH9b:  cw = word(1'b0, 1'b1, 900,  SymM, StT9,   StT9);
      StH5:   cw = word(1'b1, 1'b1, 500,  SymD, StH1,   StH4);
      StH4:   cw = word(1'b1, 1'b0, 400,  SymC, StH4b,  StH1);
      StH4b:  cw = word(1'b0, 1'b1, 400,  SymD, StT9,   StT9);
      StH1:   cw = word(1'b1, 1'b1, 100,  SymC, StH1,   StT9);
      StT9:   cw = word(1'b1, 1'b0, 90,   SymX, StT9b,  StT5);
      StT9b:  cw = word(1'b0, 1'b1, 90,   SymC, StU9,   StU9);
      StT5:   cw = word(1'b1, 1'b1, 50,   SymL, StT1,   StT4);
      StT4:   cw = word(1'b1, 1'b0, 40,   SymX, StT4b,  StT1);
      StT4b:  cw = word(1'b0, 1'b1, 40,   SymL, StU9,   StU9);
      StT1:   cw = word(1'b1, 1'b1, 10,   SymX, StT1,   StU9);
      StU9:   cw = word(1'b1, 1'b0, 9,    SymI, StU9b,  StU5);
      StU9b:  cw = word(1'b0, 1'b1, 9,    SymX, StU1,   StU1);
      StU5:   cw = word(1'b1, 1'b1, 5,    SymV, StU1,   StU4);
      StU4:   cw = word(1'b1, 1'b0, 4,    SymI, StU4b,  StU1);
      StU4b:  cw = word(1'b0, 1'b1, 4,    SymV, StU1,   StU1);
      StU1:   cw = word(1'b1, 1'b1, 1,    SymI, StU1,   StU1);
      default: cw = word(1'b0, 1'b0, 0,   SymI, StThou, StThou);
    endcase
  end

endmodule

// ----- rtl/i2r_datapath.sv -----
module i2r_datapath
  import i2r_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  dp_ctrl_t   ctrl,
  input  logic       out_ready,
  output dp_status_t status,
  output symbol_t    symbol,
  output logic       last
);

  value_t rem;
  value_t rem_sub;
  value_t rem_left;
  logic   out_valid;

  assign rem_sub  = rem - {{(ValueWidth-ConstWidth){1'b0}}, ctrl.k};
  assign rem_left = ctrl.sub ? rem_sub : rem;

  assign status.ge            = rem >= {{(ValueWidth-ConstWidth){1'b0}}, ctrl.k};
  assign status.rem_left_zero = (rem_left == '0);
  assign status.out_valid     = out_valid;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem <= ctrl.value;
    end else if (ctrl.fire && ctrl.sub) begin
      rem <= rem_sub;
    end
  end

  // output register, refilled in the cycle it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      symbol <= ctrl.sym;
      last   <= ctrl.last;
    end
  end

endmodule
